// ===== src/gpm_pkg.sv =====
// shared constants and types for the greedy point merge unit
`timescale 1ns / 1ps
package gpm_pkg;
   localparam int MaxPoints  = 64;
   localparam int IdxW       = $clog2(MaxPoints);
   localparam int CntW       = 7;
   localparam int CoordW     = 16;
   localparam int SumW       = CoordW + IdxW;
   localparam logic [15:0] ThresholdReset = 16'd160;

   typedef struct packed {
      logic load;          // write request point into store
      logic clear_sums;    // start leader: load accumulators with the leader coordinates
      logic leader_rd;     // capture leader coordinates from read data
      logic accumulate;    // add candidate coordinates into accumulators
      logic div_start;     // start both dividers
   } gpm_cmd_type;

   typedef struct packed {
      logic close;         // candidate lies strictly within the threshold
      logic div_done;      // dividers finished
   } gpm_status_type;
endpackage

// ===== src/gpm_stream_if.sv =====
// valid/ready channel interfaces for requests and responses
`timescale 1ns / 1ps
interface gpm_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] point_x;
   logic [15:0] point_y;
   logic        set_end;
   modport source (output valid, point_x, point_y, set_end, input ready);
   modport sink   (input valid, point_x, point_y, set_end, output ready);
endinterface

interface gpm_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] centroid_x;
   logic [15:0] centroid_y;
   logic [6:0]  member_count;
   logic        final_centroid;
   logic        points_dropped;
   modport source (output valid, centroid_x, centroid_y, member_count, final_centroid,
                   points_dropped, input ready);
   modport sink   (input valid, centroid_x, centroid_y, member_count, final_centroid,
                   points_dropped, output ready);
endinterface

// ===== src/gpm_ram.sv =====
// generic simple dual-port ram (one write port, one read port) with registered read
`timescale 1ns / 1ps
module gpm_ram #(
   parameter int Width = 16,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== src/gpm_divider.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module gpm_divider import gpm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SumW-1:0]   dividend,
   input  logic [CntW-1:0]   divisor,
   output logic              done,
   output logic [CoordW-1:0] quotient
);
   logic [SumW-1:0]         quo_ff, quo_in;
   logic [CntW:0]           rem_ff, rem_in;
   logic [CntW-1:0]         dsr_ff, dsr_in;
   logic [$clog2(SumW):0]   cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic [CntW:0]           trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[CntW-1:0], quo_ff[SumW-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = ($clog2(SumW)+1)'(SumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[SumW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[SumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ($clog2(SumW)+1)'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = busy_ff && (cnt_ff == ($clog2(SumW)+1)'(1));
   assign quotient = quo_in[CoordW-1:0];
endmodule

// ===== src/gpm_datapath.sv =====
// point store, distance test, accumulators and dividers
`timescale 1ns / 1ps
module gpm_datapath import gpm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  gpm_cmd_type       cmd,
   input  logic [IdxW-1:0]   wr_addr,
   input  logic [IdxW-1:0]   rd_addr,
   input  logic [15:0]       point_x,
   input  logic [15:0]       point_y,
   input  logic [15:0]       threshold,
   input  logic [CntW-1:0]   count,
   output gpm_status_type    status,
   output logic [15:0]       cx,
   output logic [15:0]       cy
);
   logic [15:0]     rx, ry;
   logic [15:0]     lx_ff, ly_ff;
   logic [SumW-1:0] sx_ff, sy_ff;
   logic [15:0]     dx_ff, dy_ff, dx_in, dy_in;
   logic [31:0]     px_ff, py_ff, lim_ff;
   logic [32:0]     d2;
   logic            dxv, dyv;
   logic            donex, doney;

   gpm_ram #(.Width(CoordW), .Depth(MaxPoints)) u_ram_x (
      .clock, .wr_en(cmd.load), .wr_addr, .wr_data(point_x), .rd_addr, .rd_data(rx));
   gpm_ram #(.Width(CoordW), .Depth(MaxPoints)) u_ram_y (
      .clock, .wr_en(cmd.load), .wr_addr, .wr_data(point_y), .rd_addr, .rd_data(ry));

   assign dx_in = (lx_ff >= rx) ? lx_ff - rx : rx - lx_ff;
   assign dy_in = (ly_ff >= ry) ? ly_ff - ry : ry - ly_ff;
   assign d2    = {1'b0, px_ff} + {1'b0, py_ff};
   assign dxv   = 1'b1;
   assign dyv   = dxv;

   // difference, then square, then compare: difference and square registered, compare combinational
   always_ff @(posedge clock) begin
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      px_ff  <= dx_ff * dx_ff;
      py_ff  <= dy_ff * dy_ff;
      lim_ff <= threshold * threshold;
      if (cmd.leader_rd) begin
         lx_ff <= rx;
         ly_ff <= ry;
      end
      if (cmd.clear_sums) begin
         sx_ff <= SumW'(rx);
         sy_ff <= SumW'(ry);
      end else if (cmd.accumulate && dyv) begin
         sx_ff <= sx_ff + SumW'(rx);
         sy_ff <= sy_ff + SumW'(ry);
      end
   end

   assign status.close = d2 < {1'b0, lim_ff};

   gpm_divider u_div_x (.clock, .reset, .start(cmd.div_start), .dividend(sx_ff),
                        .divisor(count), .done(donex), .quotient(cx));
   gpm_divider u_div_y (.clock, .reset, .start(cmd.div_start), .dividend(sy_ff),
                        .divisor(count), .done(doney), .quotient(cy));
   assign status.div_done = donex & doney;
endmodule

// ===== src/gpm_controller.sv =====
// sequencer for loading, leader walk, candidate scan and result hand-off
`timescale 1ns / 1ps
module gpm_controller import gpm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_set_end,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output logic            rsp_final,
   output logic            rsp_dropped,
   output logic [CntW-1:0] rsp_count,
   output gpm_cmd_type     cmd,
   input  gpm_status_type  status,
   output logic [IdxW-1:0] wr_addr,
   output logic [IdxW-1:0] rd_addr,
   output logic [CntW-1:0] count
);
   localparam logic [3:0] S_LOAD = 4'd0, S_LRD = 4'd1, S_LCAP = 4'd2, S_CRD = 4'd3,
                          S_CW1 = 4'd4, S_CW2 = 4'd5, S_CW3 = 4'd6, S_CDEC = 4'd7,
                          S_DIV = 4'd8, S_DWT = 4'd9, S_OUT = 4'd10;

   logic [3:0]          state_ff, state_in;
   logic [CntW-1:0]     n_ff, n_in;
   logic                ovf_ff, ovf_in;
   logic [MaxPoints-1:0] mark_ff, mark_in;
   logic [CntW-1:0]     lead_ff, lead_in, cand_ff, cand_in, cnt_ff, cnt_in;
   logic                fin_ff, fin_in;
   logic                accept;
   logic [CntW-1:0]     nxt;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_LOAD);
   assign wr_addr   = n_ff[IdxW-1:0];

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      ovf_in   = ovf_ff;
      mark_in  = mark_ff;
      lead_in  = lead_ff;
      cand_in  = cand_ff;
      cnt_in   = cnt_ff;
      fin_in   = fin_ff;
      cmd      = '0;
      rd_addr  = lead_ff[IdxW-1:0];
      nxt      = lead_ff + 1'b1;
      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (n_ff < CntW'(MaxPoints)) begin
                  cmd.load = 1'b1;
                  n_in     = n_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_set_end) begin
                  lead_in  = '0;
                  state_in = S_LRD;
               end
            end
         end
         S_LRD: begin
            // return to loading once past the last point; skip absorbed leaders; read the leader otherwise
            if (lead_ff >= n_ff) begin
               state_in = S_LOAD;
               n_in     = '0;
               ovf_in   = 1'b0;
               mark_in  = '0;
            end else if (mark_ff[lead_ff[IdxW-1:0]]) begin
               lead_in = lead_ff + 1'b1;
            end else begin
               state_in = S_LCAP;
            end
         end
         S_LCAP: begin
            cmd.leader_rd  = 1'b1;
            cmd.clear_sums = 1'b1;
            cnt_in         = CntW'(1);
            cand_in        = lead_ff + 1'b1;
            state_in       = S_CRD;
         end
         S_CRD: begin
            rd_addr = cand_ff[IdxW-1:0];
            if (cand_ff >= n_ff) begin
               state_in = S_DIV;
            end else if (mark_ff[cand_ff[IdxW-1:0]]) begin
               cand_in = cand_ff + 1'b1;
            end else begin
               state_in = S_CW1;
            end
         end
         S_CW1: begin
            rd_addr  = cand_ff[IdxW-1:0];
            state_in = S_CW2;
         end
         S_CW2: begin
            rd_addr  = cand_ff[IdxW-1:0];
            state_in = S_CW3;
         end
         S_CW3: begin
            rd_addr  = cand_ff[IdxW-1:0];
            state_in = S_CDEC;
         end
         S_CDEC: begin
            // read data still shows the candidate
            rd_addr = cand_ff[IdxW-1:0];
            if (status.close) begin
               cmd.accumulate = 1'b1;
               mark_in[cand_ff[IdxW-1:0]] = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
            cand_in  = cand_ff + 1'b1;
            state_in = S_CRD;
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            fin_in        = 1'b1;
            for (int k = 0; k < MaxPoints; k++) begin
               if (CntW'(k) > lead_ff && CntW'(k) < n_ff && !mark_ff[k]) begin
                  fin_in = 1'b0;
               end
            end
            state_in = S_DWT;
         end
         S_DWT: begin
            if (status.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               lead_in  = nxt;
               state_in = S_LRD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         n_ff     <= '0;
         ovf_ff   <= 1'b0;
         mark_ff  <= '0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         ovf_ff   <= ovf_in;
         mark_ff  <= mark_in;
      end
      lead_ff <= lead_in;
      cand_ff <= cand_in;
      cnt_ff  <= cnt_in;
      fin_ff  <= fin_in;
   end

   assign rsp_valid   = (state_ff == S_OUT);
   assign rsp_final   = fin_ff;
   assign rsp_dropped = ovf_ff;
   assign rsp_count   = cnt_ff;
   assign count       = cnt_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOAD) |-> !req_ready) else $error("input taken while merging");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (cnt_ff != '0 && cnt_ff <= n_ff)) else $error("bad member count");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result lost");
endmodule

// ===== src/greedy_point_merge_unit.sv =====
// top level of the greedy point merge unit
`timescale 1ns / 1ps
//  channel | direction | payload
//  req     | in        | point_x, point_y, set_end
//  rsp     | out       | centroid_x, centroid_y, member_count, final_centroid, points_dropped
//  csr     | in        | merge_threshold write
//
//  loading: points are taken back to back while the sequencer is loading
//  merging: per live candidate per leader a ram read, difference, square and compare,
//  plus per leader a divide (start and 22 serial steps)
//  synchronous reset returns the threshold to 10.0 pixels and empties the store
//  a stalled response holds the sequencer; no point is taken during a merge
module greedy_point_merge_unit import gpm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   gpm_req_if.sink    req,
   gpm_rsp_if.source  rsp,
   input  logic       csr_we,
   input  logic [15:0] csr_wdata
);
   logic [15:0]     thr_ff;
   gpm_cmd_type     cmd;
   gpm_status_type  status;
   logic [IdxW-1:0] wr_addr, rd_addr;
   logic [CntW-1:0] count;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ThresholdReset;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   gpm_controller u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready), .req_set_end(req.set_end),
      .rsp_ready(rsp.ready), .rsp_valid(rsp.valid), .rsp_final(rsp.final_centroid),
      .rsp_dropped(rsp.points_dropped), .rsp_count(rsp.member_count),
      .cmd, .status, .wr_addr, .rd_addr, .count);

   // quotient outputs hold once the dividers finish
   gpm_datapath u_dp (
      .clock, .reset, .cmd, .wr_addr, .rd_addr,
      .point_x(req.point_x), .point_y(req.point_y), .threshold(thr_ff), .count,
      .status, .cx(rsp.centroid_x), .cy(rsp.centroid_y));
endmodule

// ===== sim/tb.sv =====
// testbench for the greedy point merge unit: directed and random point sets checked against a predictor
`timescale 1ns / 1ps
module tb;
   import gpm_pkg::*;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic        last;
   } point_t;

   typedef struct packed {
      logic [15:0] cx;
      logic [15:0] cy;
      logic [6:0]  count;
      logic        fin;
      logic        dropped;
   } centroid_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   gpm_req_if req ();
   gpm_rsp_if rsp ();

   greedy_point_merge_unit uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [15:0] set_x [MaxPoints];
   logic [15:0] set_y [MaxPoints];
   int          set_len;
   logic        set_over;
   logic [15:0] threshold;

   point_t    points_pending [$];
   centroid_t centroids_due [$];
   int        mismatches = 0;
   int        send_gap = 0;
   int        recv_gap = 0;
   int        hold_off = 0;
   bit        stimulus_done = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // append one point to the pending queue
   task automatic add_point(point_t p);
      points_pending.insert(points_pending.size(), p);
   endtask

   // fold one accepted point into the set; merge when it closes the set
   task automatic predict_point(point_t p);
      logic            taken [MaxPoints];
      logic [32:0]     limit, d2;
      logic [15:0]     dx, dy;
      logic [SumW-1:0] sx, sy;
      int              cnt;
      centroid_t       c;
      if (set_len < MaxPoints) begin
         set_x[set_len] = p.x;
         set_y[set_len] = p.y;
         set_len++;
      end else begin
         set_over = 1'b1;
      end
      if (!p.last) return;
      limit = 33'(threshold) * 33'(threshold);
      for (int i = 0; i < MaxPoints; i++) taken[i] = 1'b0;
      for (int i = 0; i < set_len; i++) begin
         if (taken[i]) continue;
         sx = SumW'(set_x[i]);
         sy = SumW'(set_y[i]);
         cnt = 1;
         for (int j = i + 1; j < set_len; j++) begin
            if (taken[j]) continue;
            dx = (set_x[i] >= set_x[j]) ? set_x[i] - set_x[j] : set_x[j] - set_x[i];
            dy = (set_y[i] >= set_y[j]) ? set_y[i] - set_y[j] : set_y[j] - set_y[i];
            d2 = 33'(dx) * 33'(dx) + 33'(dy) * 33'(dy);
            if (d2 < limit) begin
               taken[j] = 1'b1;
               sx += SumW'(set_x[j]);
               sy += SumW'(set_y[j]);
               cnt++;
            end
         end
         c.cx = 16'(sx / cnt);
         c.cy = 16'(sy / cnt);
         c.count = 7'(cnt);
         c.fin = 1'b0;
         c.dropped = set_over;
         centroids_due.insert(centroids_due.size(), c);
      end
      // last centroid of the set carries the final mark
      c = centroids_due[$];
      c.fin = 1'b1;
      centroids_due[$] = c;
      set_len = 0;
      set_over = 1'b0;
   endtask

   // driver: offers queued points with random gaps, predicts on each transfer
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (req.valid && req.ready) begin
         predict_point(points_pending.pop_front());
         send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
         if (send_gap == 0 && points_pending.size() > 0) begin
            {req.point_x, req.point_y, req.set_end} <= points_pending[0];
         end else begin
            req.valid <= 1'b0;
         end
      end else if (!req.valid) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (points_pending.size() > 0) begin
            req.valid <= 1'b1;
            {req.point_x, req.point_y, req.set_end} <= points_pending[0];
         end
      end
   end

   // monitor: random stalls, one long hold-off on request, checks each transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (centroids_due.size() == 0) begin
               $display("%0t: expected nothing, got centroid %h", $time,
                        {rsp.centroid_x, rsp.centroid_y, rsp.member_count,
                         rsp.final_centroid, rsp.points_dropped});
               mismatches++;
            end else begin
               automatic centroid_t e = centroids_due.pop_front();
               automatic centroid_t a = {rsp.centroid_x, rsp.centroid_y,
                                         rsp.member_count, rsp.final_centroid,
                                         rsp.points_dropped};
               if (a.cx !== e.cx || a.cy !== e.cy || a.count !== e.count ||
                   a.fin !== e.fin || a.dropped !== e.dropped) begin
                  $display("%0t: expected x=%h y=%h n=%0d f=%b d=%b, got x=%h y=%h n=%0d f=%b d=%b",
                           $time, e.cx, e.cy, e.count, e.fin, e.dropped,
                           a.cx, a.cy, a.count, a.fin, a.dropped);
                  mismatches++;
               end
            end
            recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   function automatic point_t rand_point(logic [15:0] bx, logic [15:0] by, int spread,
                                         bit last);
      point_t p;
      p.x = bx + 16'($urandom_range(0, spread));
      p.y = by + 16'($urandom_range(0, spread));
      p.last = last;
      return p;
   endfunction

   // queue a set of n points clustered around random centres, with occasional scattered points
   task automatic queue_set(int n, int spread);
      logic [15:0] bx, by;
      for (int i = 0; i < n; i++) begin
         if (i % 4 == 0) begin
            bx = 16'($urandom);
            by = 16'($urandom);
         end
         if ($urandom_range(0, 9) == 0) add_point(rand_point(
               16'($urandom), 16'($urandom), 0, i == n - 1));
         else add_point(rand_point(bx, by, spread, i == n - 1));
      end
   endtask

   task automatic drain_then_write(logic [15:0] value);
      while (points_pending.size() > 0 || req.valid || centroids_due.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      threshold = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      req.valid = 1'b0;
      req.point_x = '0;
      req.point_y = '0;
      req.set_end = 1'b0;
      rsp.ready = 1'b0;
      set_len = 0;
      set_over = 1'b0;
      threshold = ThresholdReset;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, single point, identical points, threshold boundary
      add_point({16'h0000, 16'h0000, 1'b1});
      add_point({16'hffff, 16'hffff, 1'b1});
      add_point({16'hffff, 16'h0000, 1'b0});
      add_point({16'h0000, 16'hffff, 1'b0});
      add_point({16'hffff, 16'hffff, 1'b0});
      add_point({16'hffff, 16'hffff, 1'b1});
      // exactly at the threshold apart: not merged, just inside: merged
      add_point({16'd1000, 16'd1000, 1'b0});
      add_point({16'd1160, 16'd1000, 1'b0});
      add_point({16'd1000, 16'd1159, 1'b0});
      add_point({16'd1096, 16'd1128, 1'b1});
      drain_then_write(16'd0);
      // zero threshold: even identical points stay apart
      add_point({16'h1234, 16'h5678, 1'b0});
      add_point({16'h1234, 16'h5678, 1'b1});
      drain_then_write(16'hffff);
      // huge threshold with extremes: corners a full span apart still stay apart
      add_point({16'hffff, 16'h0000, 1'b0});
      add_point({16'h0000, 16'hffff, 1'b0});
      add_point({16'hffff, 16'hffff, 1'b0});
      add_point({16'h0000, 16'h0000, 1'b1});
      // overflowing set with long response hold-off; the next set backs up behind it
      queue_set(66, 8);
      queue_set(3, 50);
      hold_off = 3000;
      drain_then_write(16'd64);
      queue_set(64, 200);
      queue_set(3, 10);

      // random sets under several thresholds
      for (int phase = 0; phase < 4; phase++) begin
         drain_then_write(phase == 0 ? 16'd160 : phase == 1 ? 16'd1 :
                          phase == 2 ? 16'd2000 : 16'($urandom));
         queue_set($urandom_range(1, 8), $urandom_range(0, 300));
      end
      while (points_pending.size() > 0 || req.valid || centroids_due.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && centroids_due.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

// ===== files.f =====
src/gpm_pkg.sv
src/gpm_stream_if.sv
src/gpm_ram.sv
src/gpm_divider.sv
src/gpm_datapath.sv
src/gpm_controller.sv
src/greedy_point_merge_unit.sv
sim/tb.sv
